### design/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// shared types, register map and helpers for the line substring matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

    localparam int CHAR_BITS    = 8;
    localparam int LEN_BITS     = 4;
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 5;

    localparam logic [CHAR_BITS-1:0] WORD_LIMIT = 8'd32;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_CASE_SENSITIVE = 2'd2,
        REG_WHOLE_WORDS    = 2'd3
    } reg_index_t;

    // ascii fold of upper case letters unless matching exactly
    function automatic logic [CHAR_BITS-1:0] fold_char(
        input logic [CHAR_BITS-1:0] c,
        input logic                 exact
    );
        logic [CHAR_BITS-1:0] r;
        r = c;
        if (!exact && (c inside {[8'h41:8'h5A]}))
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/line_substring_matcher_unit.sv
// ----------------------------------------------------------------------------
// line_substring_matcher_unit
// streaming per-line search for a short pattern, optionally whole-word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Text enters one character per transaction on the input channel, with flags
// for the last character of a line, the first line of a file and an empty
// line. For every line that holds the configured pattern (1..MAX_PATTERN
// characters, optional ascii case fold, optional whole-word bounds of the
// line edge or a code at most 32) one transaction leaves on the output
// channel at the end of the line, carrying the line number and the 1-based
// column of the first qualifying match. Throughput is one character per
// clock unless a result stalls: each character is taken into the input
// register, goes through one pass of parallel window compares, and lands
// in the result register, which offers the result transaction for the
// character closing its line. The output register frees up in the same cycle
// its transaction is taken, so the stream only stalls while a result waits
// with ready held low on the result side. Registers sit on an APB port at
// byte addresses 0, 8, 16 and 24 (64-bit data); program them while the
// stream is idle.

module line_substring_matcher_unit
    import lsm_pkg::*;
#(
    parameter int MAX_PATTERN = 8,
    parameter int COLUMN_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  wire                     clk,
    input  wire                     rst_n,

    // apb configuration port
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [APB_ADDR_W-1:0]   paddr,
    input  wire  [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,

    // character input channel
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [CHAR_BITS-1:0]    char_code,
    input  wire                     last_in_line,
    input  wire                     first_of_file,
    input  wire                     empty_line,

    // result output channel
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [LINE_BITS-1:0]    line_number,
    output logic [COLUMN_BITS-1:0]  column
);

    localparam logic [COLUMN_BITS-1:0] ColMax  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LineMax = {LINE_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]    MaxLen  = LEN_BITS'(MAX_PATTERN);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [APB_DATA_W-1:0] pattern_bytes_reg;
    logic [LEN_BITS-1:0]   pattern_length_reg;
    logic                  case_sensitive_reg;
    logic                  whole_words_reg;

    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            case_sensitive_reg <= 1'b0;
            whole_words_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= pwdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[LEN_BITS-1:0];
                REG_CASE_SENSITIVE: case_sensitive_reg <= pwdata[0];
                REG_WHOLE_WORDS:    whole_words_reg    <= pwdata[0];
                default:            pattern_bytes_reg  <= pattern_bytes_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_index)
            REG_PATTERN_BYTES:  prdata = pattern_bytes_reg;
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length_reg);
            REG_CASE_SENSITIVE: prdata = APB_DATA_W'(case_sensitive_reg);
            REG_WHOLE_WORDS:    prdata = APB_DATA_W'(whole_words_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic [CHAR_BITS-1:0] s1_char_reg;
    logic                 s1_last_reg;
    logic                 s1_first_reg;
    logic                 s1_empty_reg;

    logic out_free;
    logic s1_fire;

    // the result slot is free when empty or being drained this cycle
    assign out_free = !out_valid || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg  <= char_code;
            s1_last_reg  <= last_in_line;
            s1_first_reg <= first_of_file;
            s1_empty_reg <= empty_line;
        end
    end

    // ------------------------------------------------------------------
    // line state
    // ------------------------------------------------------------------
    // window holds the most recent raw characters, newest in entry 0
    logic [CHAR_BITS-1:0]   window_reg [MAX_PATTERN];
    logic [CHAR_BITS-1:0]   window_next [MAX_PATTERN];
    logic [COLUMN_BITS-1:0] column_count_reg, column_count_next;
    logic [LINE_BITS-1:0]   line_count_reg, line_count_next;
    logic                   match_found_reg, match_found_next;
    logic [COLUMN_BITS-1:0] match_column_reg, match_column_next;
    logic                   pending_match_reg, pending_match_next;
    logic [COLUMN_BITS-1:0] pending_column_reg, pending_column_next;

    logic                   result_valid;
    logic [COLUMN_BITS-1:0] result_column;

    // window after shifting in the current character
    logic [CHAR_BITS-1:0]   win_new [MAX_PATTERN+1];

    always_comb
    begin
        logic                   line_start;
        logic                   col_ok;
        logic [COLUMN_BITS-1:0] newcol;
        logic                   len_ok;
        logic                   hit;
        logic                   bound_ok;
        logic                   k_hit;
        logic [COLUMN_BITS-1:0] len_col;
        logic [COLUMN_BITS-1:0] start_col;

        window_next         = window_reg;
        column_count_next   = column_count_reg;
        line_count_next     = line_count_reg;
        match_found_next    = match_found_reg;
        match_column_next   = match_column_reg;
        pending_match_next  = pending_match_reg;
        pending_column_next = pending_column_reg;
        result_valid        = 1'b0;
        result_column       = match_column_reg;

        line_start = (column_count_reg == '0);
        col_ok     = (column_count_reg != ColMax);
        newcol     = col_ok ? column_count_reg + COLUMN_BITS'(1) : ColMax;
        len_col    = COLUMN_BITS'(pattern_length_reg);
        start_col  = newcol - len_col + COLUMN_BITS'(1);
        len_ok     = (pattern_length_reg != '0) && (pattern_length_reg <= MaxLen);

        win_new[0] = s1_char_reg;
        for (int j = 1; j <= MAX_PATTERN; j++)
        begin
            win_new[j] = window_reg[j-1];
        end

        // pick the compare result and the left bound for the active length
        hit      = 1'b0;
        bound_ok = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            k_hit = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (fold_char(pattern_bytes_reg[8*k +: 8], case_sensitive_reg) !=
                    fold_char(win_new[l-1-k], case_sensitive_reg))
                begin
                    k_hit = 1'b0;
                end
            end
            if (pattern_length_reg == LEN_BITS'(l))
            begin
                hit      = k_hit;
                bound_ok = (win_new[l] <= WORD_LIMIT);
            end
        end
        bound_ok = bound_ok || (newcol == len_col);

        if (s1_fire)
        begin
            // first item of a line opens it
            if (line_start)
            begin
                if (s1_first_reg)
                begin
                    line_count_next = LINE_BITS'(1);
                end
                else if (line_count_reg != LineMax)
                begin
                    line_count_next = line_count_reg + LINE_BITS'(1);
                end
                match_found_next   = 1'b0;
                pending_match_next = 1'b0;
            end

            if (s1_empty_reg)
            begin
                // empty marker mid-line closes the line with no character
                if (!line_start)
                begin
                    if (pending_match_next && !match_found_next)
                    begin
                        result_valid  = 1'b1;
                        result_column = pending_column_reg;
                    end
                    else if (match_found_next)
                    begin
                        result_valid  = 1'b1;
                        result_column = match_column_reg;
                    end
                    column_count_next  = '0;
                    match_found_next   = 1'b0;
                    pending_match_next = 1'b0;
                end
            end
            else
            begin
                // settle a whole-word candidate on its right bound
                if (pending_match_next)
                begin
                    if (!match_found_next && (s1_char_reg <= WORD_LIMIT))
                    begin
                        match_found_next  = 1'b1;
                        match_column_next = pending_column_reg;
                    end
                    pending_match_next = 1'b0;
                end

                for (int j = 0; j < MAX_PATTERN; j++)
                begin
                    window_next[j] = win_new[j];
                end

                if (!match_found_next && col_ok && len_ok && (newcol >= len_col) && hit)
                begin
                    if (!whole_words_reg)
                    begin
                        match_found_next  = 1'b1;
                        match_column_next = start_col;
                    end
                    else if (bound_ok)
                    begin
                        pending_match_next  = 1'b1;
                        pending_column_next = start_col;
                    end
                end

                if (s1_last_reg)
                begin
                    if (pending_match_next && !match_found_next)
                    begin
                        result_valid  = 1'b1;
                        result_column = pending_column_next;
                    end
                    else if (match_found_next)
                    begin
                        result_valid  = 1'b1;
                        result_column = match_column_next;
                    end
                    column_count_next  = '0;
                    match_found_next   = 1'b0;
                    pending_match_next = 1'b0;
                end
                else
                begin
                    column_count_next = newcol;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                window_reg[j] <= '0;
            end
            column_count_reg   <= '0;
            line_count_reg     <= '0;
            match_found_reg    <= 1'b0;
            match_column_reg   <= '0;
            pending_match_reg  <= 1'b0;
            pending_column_reg <= '0;
        end
        else
        begin
            window_reg         <= window_next;
            column_count_reg   <= column_count_next;
            line_count_reg     <= line_count_next;
            match_found_reg    <= match_found_next;
            match_column_reg   <= match_column_next;
            pending_match_reg  <= pending_match_next;
            pending_column_reg <= pending_column_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                   out_valid_reg;
    logic [LINE_BITS-1:0]   line_number_reg;
    logic [COLUMN_BITS-1:0] column_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && result_valid)
        begin
            line_number_reg <= line_count_next;
            column_reg      <= result_column;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_number = line_number_reg;
    assign column      = column_reg;

endmodule

`default_nettype wire

### design/lsm_checker.sv
// ----------------------------------------------------------------------------
// lsm_checker
// port-level checks for the line substring matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsm_checker
    import lsm_pkg::*;
#(
    parameter int COLUMN_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    psel,
    input wire                    penable,
    input wire                    pwrite,
    input wire [APB_ADDR_W-1:0]   paddr,
    input wire [APB_DATA_W-1:0]   pwdata,
    input wire [APB_DATA_W-1:0]   prdata,
    input wire                    out_valid,
    input wire                    out_ready,
    input wire [LINE_BITS-1:0]    line_number,
    input wire [COLUMN_BITS-1:0]  column
);

    // stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_number) && $stable(column))
        else $error("result changed while stalled");

    // a result only goes away after it was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without handshake");

    // reported positions are 1-based
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_number != '0) && (column != '0))
        else $error("zero line or column reported");

    // case flag reads back what was just written
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[4:3] == REG_CASE_SENSITIVE))
        ##1 (psel && !pwrite && (paddr[4:3] == REG_CASE_SENSITIVE))
        |-> (prdata[0] == $past(pwdata[0])) && (prdata[APB_DATA_W-1:1] == '0))
        else $error("case flag read back mismatch");

endmodule

bind line_substring_matcher_unit lsm_checker #(
    .COLUMN_BITS(COLUMN_BITS),
    .LINE_BITS  (LINE_BITS)
) u_lsm_checker (.*);

`default_nettype wire
